// File: hw/rtl/blw_pkg.sv
// Shared definitions for the line walker: command codes, direction bundle and
// the default coordinate width. No dependencies.
package blw_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COLOR_BITS = 32;

   typedef enum logic {
      CMD_START   = 1'b0,
      CMD_ADVANCE = 1'b1
   } blw_cmd_type;

   // Step directions of a line, one bit per axis.
   typedef struct packed {
      logic x_neg;
      logic y_neg;
   } blw_dir_type;

endpackage

// File: hw/rtl/blw_delta.sv
// Endpoint front end: absolute deltas and step directions of a start request.
// Depends on blw_pkg.
module blw_delta #(
   parameter int COORD_BITS = blw_pkg::COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic [COORD_BITS-1:0]        abs_dx,
   output logic [COORD_BITS-1:0]        abs_dy,
   output blw_pkg::blw_dir_type         dir
);
   import blw_pkg::*;

   logic [COORD_BITS:0] dx_fwd;
   logic [COORD_BITS:0] dx_rev;
   logic [COORD_BITS:0] dy_fwd;
   logic [COORD_BITS:0] dy_rev;

   // Both differences are formed side by side, so the absolute value is a mux.
   assign dx_fwd = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
   assign dx_rev = {start_x[COORD_BITS-1], start_x} - {end_x[COORD_BITS-1], end_x};
   assign dy_fwd = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
   assign dy_rev = {start_y[COORD_BITS-1], start_y} - {end_y[COORD_BITS-1], end_y};

   assign dir.x_neg = dx_fwd[COORD_BITS];
   assign dir.y_neg = dy_fwd[COORD_BITS];
   assign abs_dx = dx_fwd[COORD_BITS] ? dx_rev[COORD_BITS-1:0] : dx_fwd[COORD_BITS-1:0];
   assign abs_dy = dy_fwd[COORD_BITS] ? dy_rev[COORD_BITS-1:0] : dy_fwd[COORD_BITS-1:0];

endmodule

// File: hw/rtl/blw_walk.sv
// Line state and the Bresenham step: loads a line on start, steps it on
// advance, and presents the pixel produced by the consumed request.
// Depends on blw_pkg.
module blw_walk #(
   parameter int COORD_BITS = blw_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  blw_pkg::blw_cmd_type         cmd,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0]        abs_dx,
   input  logic [COORD_BITS-1:0]        abs_dy,
   input  blw_pkg::blw_dir_type         dir,
   input  logic [blw_pkg::COLOR_BITS-1:0] color,
   output logic                         res_valid,
   output logic signed [COORD_BITS-1:0] res_x,
   output logic signed [COORD_BITS-1:0] res_y,
   output logic [blw_pkg::COLOR_BITS-1:0] res_color,
   output logic                         res_last
);
   import blw_pkg::*;

   localparam int EW = COORD_BITS + 3;

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [EW-1:0]                err_ff, err_in;
   logic [EW-1:0]                inc_minor_ff, inc_minor_in;
   logic [EW-1:0]                inc_both_ff, inc_both_in;
   blw_dir_type                  dir_ff, dir_in;
   logic                         x_major_ff, x_major_in;
   logic [COORD_BITS-1:0]        left_ff, left_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic                         active_ff, active_in;

   logic                         x_major_new;
   logic [COORD_BITS-1:0]        major_new;
   logic [EW-1:0]                adx_ext, ady_ext;
   logic [EW-1:0]                err_xm, err_ym, diff_xm, diff_ym;
   logic                         err_ge;
   logic                         x_move, y_move;
   logic [COORD_BITS-1:0]        x_inc, y_inc;
   logic [COORD_BITS-1:0]        left_dec;

   // Setup terms for a new line; both axis choices are formed in parallel
   // with the compare that picks one.
   assign adx_ext = {3'b000, abs_dx};
   assign ady_ext = {3'b000, abs_dy};
   assign x_major_new = abs_dx > abs_dy;
   assign major_new = x_major_new ? abs_dx : abs_dy;
   assign err_xm  = {2'b00, abs_dy, 1'b0} - adx_ext;
   assign err_ym  = {2'b00, abs_dx, 1'b0} - ady_ext;
   assign diff_xm = {ady_ext[EW-2:0], 1'b0} - {adx_ext[EW-2:0], 1'b0};
   assign diff_ym = {adx_ext[EW-2:0], 1'b0} - {ady_ext[EW-2:0], 1'b0};

   // One step: the major axis always moves, the minor one when the error
   // term is not negative.
   assign err_ge   = ~err_ff[EW-1];
   assign x_move   = x_major_ff | err_ge;
   assign y_move   = ~x_major_ff | err_ge;
   assign x_inc    = x_move ? {{(COORD_BITS-1){dir_ff.x_neg}}, 1'b1} : '0;
   assign y_inc    = y_move ? {{(COORD_BITS-1){dir_ff.y_neg}}, 1'b1} : '0;
   assign left_dec = left_ff - 1'b1;

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_in       = err_ff;
      inc_minor_in = inc_minor_ff;
      inc_both_in  = inc_both_ff;
      dir_in       = dir_ff;
      x_major_in   = x_major_ff;
      left_in      = left_ff;
      color_in     = color_ff;
      active_in    = active_ff;
      res_valid    = 1'b0;
      res_x        = cur_x_ff;
      res_y        = cur_y_ff;
      res_color    = color_ff;
      res_last     = 1'b0;
      case (cmd)
         CMD_START: begin
            cur_x_in     = start_x;
            cur_y_in     = start_y;
            err_in       = x_major_new ? err_xm : err_ym;
            inc_minor_in = x_major_new ? {ady_ext[EW-2:0], 1'b0} : {adx_ext[EW-2:0], 1'b0};
            inc_both_in  = x_major_new ? diff_xm : diff_ym;
            dir_in       = dir;
            x_major_in   = x_major_new;
            left_in      = major_new;
            color_in     = color;
            active_in    = major_new != '0;
            res_valid    = 1'b1;
            res_x        = start_x;
            res_y        = start_y;
            res_color    = color;
            res_last     = major_new == '0;
         end
         CMD_ADVANCE: begin
            if (active_ff) begin
               cur_x_in  = cur_x_ff + x_inc;
               cur_y_in  = cur_y_ff + y_inc;
               err_in    = err_ff + (err_ge ? inc_both_ff : inc_minor_ff);
               left_in   = left_dec;
               active_in = left_dec != '0;
               res_valid = 1'b1;
               res_x     = cur_x_ff + x_inc;
               res_y     = cur_y_ff + y_inc;
               res_last  = left_dec == '0;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (fire) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         err_ff       <= err_in;
         inc_minor_ff <= inc_minor_in;
         inc_both_ff  <= inc_both_in;
         dir_ff       <= dir_in;
         x_major_ff   <= x_major_in;
         left_ff      <= left_in;
         color_ff     <= color_in;
      end
   end

endmodule

// File: hw/rtl/bresenham_line_walker_core.sv
// Top level of the Bresenham line walker: request register, line state and
// pixel result register. Depends on blw_pkg, blw_delta and blw_walk.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   cmd, endpoints, pixel_color
//   rsp       out         rsp_valid / rsp_ready   pixel_x, pixel_y, color_out, last
//
// A request is registered after the delta front end and consumed from the request
// register when its pixel is loaded into the result register; one request per
// cycle is sustained while the result register is not stalled.
// Reset is synchronous and leaves no line active. An advance with no active
// line is consumed without a pixel. A stalled pixel holds both registers;
// the request register still takes a request while it is empty.
module bresenham_line_walker_core #(
   parameter int COORD_BITS = blw_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  blw_pkg::blw_cmd_type           req_cmd,
   input  logic signed [COORD_BITS-1:0]   req_start_x,
   input  logic signed [COORD_BITS-1:0]   req_start_y,
   input  logic signed [COORD_BITS-1:0]   req_end_x,
   input  logic signed [COORD_BITS-1:0]   req_end_y,
   input  logic [blw_pkg::COLOR_BITS-1:0] req_pixel_color,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [COORD_BITS-1:0]   rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]   rsp_pixel_y,
   output logic [blw_pkg::COLOR_BITS-1:0] rsp_color_out,
   output logic                           rsp_last
);
   import blw_pkg::*;

   logic                         s1_valid_ff, s1_valid_in;
   blw_cmd_type                  s1_cmd_ff;
   logic signed [COORD_BITS-1:0] s1_x_ff;
   logic signed [COORD_BITS-1:0] s1_y_ff;
   logic [COORD_BITS-1:0]        s1_adx_ff;
   logic [COORD_BITS-1:0]        s1_ady_ff;
   blw_dir_type                  s1_dir_ff;
   logic [COLOR_BITS-1:0]        s1_color_ff;

   logic                         out_valid_ff, out_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff;
   logic signed [COORD_BITS-1:0] out_y_ff;
   logic [COLOR_BITS-1:0]        out_color_ff;
   logic                         out_last_ff;

   logic [COORD_BITS-1:0]        abs_dx;
   logic [COORD_BITS-1:0]        abs_dy;
   blw_dir_type                  dir;
   logic                         advance;
   logic                         fire;
   logic                         take;
   logic                         res_valid;
   logic signed [COORD_BITS-1:0] res_x;
   logic signed [COORD_BITS-1:0] res_y;
   logic [COLOR_BITS-1:0]        res_color;
   logic                         res_last;

   blw_delta #(.COORD_BITS(COORD_BITS)) u_delta (
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .abs_dx  (abs_dx),
      .abs_dy  (abs_dy),
      .dir     (dir)
   );

   blw_walk #(.COORD_BITS(COORD_BITS)) u_walk (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .cmd       (s1_cmd_ff),
      .start_x   (s1_x_ff),
      .start_y   (s1_y_ff),
      .abs_dx    (s1_adx_ff),
      .abs_dy    (s1_ady_ff),
      .dir       (s1_dir_ff),
      .color     (s1_color_ff),
      .res_valid (res_valid),
      .res_x     (res_x),
      .res_y     (res_y),
      .res_color (res_color),
      .res_last  (res_last)
   );

   // The result register can load whenever it is empty or being drained.
   assign advance   = ~out_valid_ff | rsp_ready;
   assign fire      = s1_valid_ff & advance;
   assign req_ready = ~s1_valid_ff | advance;
   assign take      = req_valid & req_ready;

   assign s1_valid_in  = take | (s1_valid_ff & ~fire);
   assign out_valid_in = advance ? (fire & res_valid) : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff   <= req_cmd;
         s1_x_ff     <= req_start_x;
         s1_y_ff     <= req_start_y;
         s1_adx_ff   <= abs_dx;
         s1_ady_ff   <= abs_dy;
         s1_dir_ff   <= dir;
         s1_color_ff <= req_pixel_color;
      end
   end

   always_ff @(posedge clock) begin
      if (fire & res_valid) begin
         out_x_ff     <= res_x;
         out_y_ff     <= res_y;
         out_color_ff <= res_color;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_x   = out_x_ff;
   assign rsp_pixel_y   = out_y_ff;
   assign rsp_color_out = out_color_ff;
   assign rsp_last      = out_last_ff;

endmodule
